FILE: rtl/shamh_pkg.sv
// ---------------------------------------------------------------------------
// shamh_pkg
// Shared types, constants and round functions of the SHA-512 hasher.
// ---------------------------------------------------------------------------
package shamh_pkg;

    localparam int unsigned WordW   = 64;
    localparam int unsigned NWords  = 16;
    localparam int unsigned NRounds = 80;
    localparam int unsigned LenW    = 64;

    typedef logic [WordW-1:0] t_word;

    typedef struct packed {
        logic       load_byte;
        logic       pad;
        logic       zlen;
        logic       start;
        logic       round;
        logic       fin;
        logic       final_blk;
        logic [6:0] rnd;
    } t_cmd;

    typedef struct packed {
        logic fill_full;
        logic fill_hi;
    } t_sts;

    function automatic t_word init_chain(input logic [2:0] idx);
        t_word r;
        case (idx)
            3'd0: r = 64'h6A09E667F3BCC908;
            3'd1: r = 64'hBB67AE8584CAA73B;
            3'd2: r = 64'h3C6EF372FE94F82B;
            3'd3: r = 64'hA54FF53A5F1D36F1;
            3'd4: r = 64'h510E527FADE682D1;
            3'd5: r = 64'h9B05688C2B3E6C1F;
            3'd6: r = 64'h1F83D9ABFB41BD6B;
            default: r = 64'h5BE0CD19137E2179;
        endcase
        return r;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word round_k(input logic [6:0] t);
        t_word r;
        case (t)
            7'd0:  r = 64'h428a2f98d728ae22; 7'd1:  r = 64'h7137449123ef65cd;
            7'd2:  r = 64'hb5c0fbcfec4d3b2f; 7'd3:  r = 64'he9b5dba58189dbbc;
            7'd4:  r = 64'h3956c25bf348b538; 7'd5:  r = 64'h59f111f1b605d019;
            7'd6:  r = 64'h923f82a4af194f9b; 7'd7:  r = 64'hab1c5ed5da6d8118;
            7'd8:  r = 64'hd807aa98a3030242; 7'd9:  r = 64'h12835b0145706fbe;
            7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
            7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
            7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
            7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
            7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
            7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
            7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
            7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
            7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
            7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
            7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
            7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
            7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
            7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
            7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
            7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
            7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
            7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
            7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
            7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
            7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
            7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
            7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
            7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
            7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
            7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
            7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
            7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
            7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
            7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
            7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
            7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
            7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
            7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
            7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/sha512_message_hasher_core.sv
// ---------------------------------------------------------------------------
// sha512_message_hasher_core
// SHA-512 over a byte stream, one digest per message.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one item: a byte (when i_has_data)
// and an end-of-message flag (i_last_byte). An empty item with the flag set
// ends the message without adding a byte.
// Output channel: o_valid / i_stall carry the 512-bit digest as eight words,
// word 0 most significant, one item per message.
// A byte that does not complete a block is taken without a stall. A byte that
// fills the 128-byte block holds o_stall through the load, 80 rounds and the
// fold; the single round unit is the reason. A message end costs one padding
// step plus one compression, or two when fewer than 16 bytes stay free after
// the pad byte, with a load of the length block between them; the digest is
// then shown until taken and intake stays stalled while it waits.
// After reset the chain holds the standard initial values and the byte and
// length counters are zero; the same happens after every digest.
// ---------------------------------------------------------------------------
module sha512_message_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_data,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word_0,
    output logic [63:0] o_digest_word_1,
    output logic [63:0] o_digest_word_2,
    output logic [63:0] o_digest_word_3,
    output logic [63:0] o_digest_word_4,
    output logic [63:0] o_digest_word_5,
    output logic [63:0] o_digest_word_6,
    output logic [63:0] o_digest_word_7
);

    shamh_pkg::t_cmd  cmd;
    shamh_pkg::t_sts  sts;
    shamh_pkg::t_word dig [8];

    shamh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_has_data  (i_has_data),
        .i_last_byte (i_last_byte),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    shamh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_data_byte),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_dig       (dig)
    );

    assign o_digest_word_0 = dig[0];
    assign o_digest_word_1 = dig[1];
    assign o_digest_word_2 = dig[2];
    assign o_digest_word_3 = dig[3];
    assign o_digest_word_4 = dig[4];
    assign o_digest_word_5 = dig[5];
    assign o_digest_word_6 = dig[6];
    assign o_digest_word_7 = dig[7];

endmodule

FILE: rtl/shamh_ctrl.sv
// ---------------------------------------------------------------------------
// shamh_ctrl
// Sequencer: byte intake, compression rounds, padding and digest handoff.
// ---------------------------------------------------------------------------
module shamh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_has_data,
    input  logic            i_last_byte,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  shamh_pkg::t_sts i_sts,
    output shamh_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_RND   = 7'b0000100,
        S_FIN   = 7'b0001000,
        S_PAD   = 7'b0010000,
        S_ZLEN  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef enum logic [2:0] {
        PH_ABS   = 3'b001,
        PH_PAD1  = 3'b010,
        PH_FINAL = 3'b100
    } t_phase;

    t_state     r_state, n_state;
    t_phase     r_ph, n_ph;
    logic       r_pend, n_pend;
    logic [6:0] r_rnd, n_rnd;
    logic       acc;

    assign acc     = (r_state == S_IDLE) && i_valid;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_pend  = r_pend;
        n_rnd   = r_rnd;
        o_cmd   = '0;
        o_cmd.rnd = r_rnd;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_byte = acc && i_has_data;
                if (acc && i_has_data && i_sts.fill_full) begin
                    n_ph    = PH_ABS;
                    n_pend  = i_last_byte;
                    n_state = S_START;
                end else if (acc && i_last_byte) begin
                    n_state = S_PAD;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_rnd       = '0;
                n_state     = S_RND;
            end
            S_RND: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + 7'd1;
                if (r_rnd == 7'(shamh_pkg::NRounds - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin       = 1'b1;
                o_cmd.final_blk = (r_ph == PH_FINAL);
                case (r_ph)
                    PH_ABS:   n_state = r_pend ? S_PAD : S_IDLE;
                    PH_PAD1:  n_state = S_ZLEN;
                    default:  n_state = S_OUT;
                endcase
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                n_ph      = i_sts.fill_hi ? PH_PAD1 : PH_FINAL;
                n_state   = S_START;
            end
            S_ZLEN: begin
                o_cmd.zlen = 1'b1;
                n_ph       = PH_FINAL;
                n_state    = S_START;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_ABS;
            r_pend  <= 1'b0;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_pend  <= n_pend;
            r_rnd   <= n_rnd;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND) |-> (r_rnd < 7'(shamh_pkg::NRounds)))
        else $error("round count out of range");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_stall) |=> (r_state == S_IDLE))
        else $error("digest handoff did not return to idle");
    a_fin_after_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ($past(r_state) == S_RND))
        else $error("finalize without rounds");

endmodule

FILE: rtl/shamh_dp.sv
// ---------------------------------------------------------------------------
// shamh_dp
// Datapath: block words, message schedule, round logic, chain and length.
// ---------------------------------------------------------------------------
module shamh_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_byte,
    input  shamh_pkg::t_cmd   i_cmd,
    output shamh_pkg::t_sts   o_sts,
    output shamh_pkg::t_word  o_dig [8]
);

    shamh_pkg::t_word r_w     [16];
    shamh_pkg::t_word r_chain [8];
    shamh_pkg::t_word r_v     [8];
    shamh_pkg::t_word r_dig   [8];
    logic [6:0]                     r_fill;
    logic [shamh_pkg::LenW-1:0]     r_len;

    shamh_pkg::t_word pad_w [16];
    shamh_pkg::t_word len_hi, len_lo, w_new, t1, t2, s0, s1;

    assign len_hi = {61'd0, r_len[63:61]};
    assign len_lo = {r_len[60:0], 3'd0};

    assign o_sts.fill_full = (r_fill == 7'd127);
    assign o_sts.fill_hi   = (r_fill >= 7'd112);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            for (int k = 0; k < 8; k++) begin
                if (7'(i * 8 + k) < r_fill) begin
                    pad_w[i][8*(7-k) +: 8] = r_w[i][8*(7-k) +: 8];
                end else if (7'(i * 8 + k) == r_fill) begin
                    pad_w[i][8*(7-k) +: 8] = 8'h80;
                end else begin
                    pad_w[i][8*(7-k) +: 8] = 8'h00;
                end
            end
        end
    end

    always_comb begin
        s0 = shamh_pkg::rotr(r_w[1], 1) ^ shamh_pkg::rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        s1 = shamh_pkg::rotr(r_w[14], 19) ^ shamh_pkg::rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        t1 = r_v[7]
           + (shamh_pkg::rotr(r_v[4], 14) ^ shamh_pkg::rotr(r_v[4], 18)
              ^ shamh_pkg::rotr(r_v[4], 41))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + shamh_pkg::round_k(i_cmd.rnd) + r_w[0];
        t2 = (shamh_pkg::rotr(r_v[0], 28) ^ shamh_pkg::rotr(r_v[0], 34)
              ^ shamh_pkg::rotr(r_v[0], 39))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            for (int i = 0; i < 16; i++) begin
                for (int k = 0; k < 8; k++) begin
                    if (7'(i * 8 + k) == r_fill) begin
                        r_w[i][8*(7-k) +: 8] <= i_data_byte;
                    end
                end
            end
        end else if (i_cmd.pad) begin
            for (int i = 0; i < 14; i++) begin
                r_w[i] <= pad_w[i];
            end
            r_w[14] <= o_sts.fill_hi ? pad_w[14] : len_hi;
            r_w[15] <= o_sts.fill_hi ? pad_w[15] : len_lo;
        end else if (i_cmd.zlen) begin
            for (int i = 0; i < 14; i++) begin
                r_w[i] <= '0;
            end
            r_w[14] <= len_hi;
            r_w[15] <= len_lo;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
        if (i_cmd.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_cmd.fin && i_cmd.final_blk) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= shamh_pkg::init_chain(3'(i));
            end
            r_fill <= '0;
            r_len  <= '0;
        end else if (i_cmd.fin) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= i_cmd.final_blk ? shamh_pkg::init_chain(3'(i))
                                              : r_chain[i] + r_v[i];
            end
            if (i_cmd.final_blk) begin
                r_fill <= '0;
                r_len  <= '0;
            end
        end else if (i_cmd.load_byte) begin
            r_fill <= r_fill + 7'd1;
            r_len  <= r_len + 64'd1;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_dig[i] = r_dig[i];
        end
    end

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SHA-512 byte-stream hasher.
// A table of directed items (empty message, "abc", ignored idle items,
// single-byte and extreme byte values) runs first, then random messages with
// lengths around the padding and block boundaries. A local SHA-512 model
// predicts digests the table lacks; all are compared word by word in order.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0][63:0] t_digest;

    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       known;
        t_digest    digest;
    } t_stim_row;

    localparam t_digest EMPTY_DIGEST = {
        64'ha538327af927da3e, 64'h63b931bd47417a81, 64'hff8318d2877eec2f,
        64'h47d0d13c5d85f2b0, 64'h83f4a921d36ce9ce, 64'hd620e4050b5715dc,
        64'hf1542850d66d8007, 64'hcf83e1357eefb8bd};
    localparam t_digest ABC_DIGEST = {
        64'h2a9ac94fa54ca49f, 64'h454d4423643ce80e, 64'h36ba3c23a3feebbd,
        64'h2192992a274fc1a8, 64'h0a9eeee64b55d39a, 64'h12e6fa4e89a97ea2,
        64'hcc417349ae204131, 64'hddaf35a193617aba};

    localparam logic [63:0] ROUND_CONST [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    localparam logic [63:0] IV [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
        64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

    localparam int TARGET_ITEMS = 750;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_has_data = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    t_digest     dut_digest;

    logic [63:0] hash_state [8];
    logic [7:0]  msg_block [128];
    int          block_fill;
    logic [63:0] byte_count;
    t_digest     pending_digests [$];

    bit          quiet = 1'b0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          digests_seen = 0;
    int          bytes_sent = 0;
    int          long_msgs = 0;

    sha512_message_hasher_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_has_data      (i_has_data),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_digest_word_0 (dut_digest[0]),
        .o_digest_word_1 (dut_digest[1]),
        .o_digest_word_2 (dut_digest[2]),
        .o_digest_word_3 (dut_digest[3]),
        .o_digest_word_4 (dut_digest[4]),
        .o_digest_word_5 (dut_digest[5]),
        .o_digest_word_6 (dut_digest[6]),
        .o_digest_word_7 (dut_digest[7])
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic void hash_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) begin
            w[i] = '0;
            for (int b = 0; b < 8; b++) w[i] = {w[i][55:0], msg_block[i*8+b]};
        end
        for (int t = 16; t < 80; t++) begin
            s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
            s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 80; t++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
        block_fill = 0;
        byte_count = '0;
    endfunction

    // returns 1 and the digest when the item ends a message
    function automatic bit absorb_item(logic [7:0] data, logic has, logic last,
                                       output t_digest digest);
        logic [127:0] bit_len;
        if (has) begin
            msg_block[block_fill] = data;
            block_fill++;
            byte_count++;
            if (block_fill == 128) begin
                hash_block();
                block_fill = 0;
            end
        end
        if (!last) return 1'b0;
        bit_len = {61'd0, byte_count, 3'd0};
        msg_block[block_fill] = 8'h80;
        for (int i = block_fill + 1; i < 128; i++) msg_block[i] = '0;
        if (127 - block_fill < 16) begin
            hash_block();
            for (int i = 0; i < 128; i++) msg_block[i] = '0;
        end
        for (int i = 0; i < 16; i++) msg_block[112+i] = bit_len[127-8*i -: 8];
        hash_block();
        for (int i = 0; i < 8; i++) digest[i] = hash_state[i];
        restart_message();
        return 1'b1;
    endfunction

    task automatic send_item(logic [7:0] data, logic has, logic last,
                             bit known = 1'b0, t_digest typed = '0);
        int gap;
        t_digest digest;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_has_data  <= has;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        if (has || last) items_sent++;
        if (has) bytes_sent++;
        if (absorb_item(data, has, last, digest))
            pending_digests.push_back(known ? typed : digest);
    endtask

    task automatic send_message(int len, bit noisy);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 4) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
        end
        if (len == 0 || !i_last_byte) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    always @(posedge i_clk) begin
        t_digest want;
        if (i_rst_n && o_valid && !i_stall) begin
            digests_seen++;
            if (pending_digests.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest %h", dut_digest);
            end else begin
                want = pending_digests.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (dut_digest[i] !== want[i]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest %0d word %0d: expected %h got %h",
                                     digests_seen, i, want[i], dut_digest[i]);
                    end
                end
            end
        end
    end

    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 12);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_stim_row table_rows [$];
        int boundary [11] = '{110, 111, 112, 113, 127, 128, 129, 239, 240, 255, 256};
        int len;
        table_rows = '{
            '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
            '{8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{8'h61, 1'b1, 1'b0, 1'b0, '0},
            '{8'h62, 1'b1, 1'b0, 1'b0, '0},
            '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
            '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, 1'b0, '0},
            '{8'hAA, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
            '{8'h80, 1'b1, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b1, 1'b0, 1'b0, '0},
            '{8'h55, 1'b0, 1'b1, 1'b0, '0},
            '{8'h55, 1'b1, 1'b1, 1'b0, '0}
        };
        restart_message();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[r])
            send_item(table_rows[r].data, table_rows[r].has, table_rows[r].last,
                      table_rows[r].known, table_rows[r].digest);

        while (items_sent < TARGET_ITEMS) begin
            if (items_sent > TARGET_ITEMS - 120) quiet = 1'b1;
            case ($urandom_range(0, 9))
                6: begin
                    len = boundary[$urandom_range(0, 10)];
                    long_msgs++;
                end
                7: len = $urandom_range(0, 300);
                default: len = $urandom_range(0, 24);
            endcase
            send_message(len, $urandom_range(0, 3) == 0);
        end
        i_valid <= 1'b0;

        while (pending_digests.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d items (%0d bytes) hashed into %0d digests, %0d boundary-length messages",
                 items_sent, bytes_sent, digests_seen, long_msgs);
        if (mismatches == 0 && pending_digests.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
